// ===== rtl/rgb_hue_color_classifier_macros.svh =====
// Assertion macros used by the classification stage of the hue classifier.
`ifndef RGB_HUE_COLOR_CLASSIFIER_MACROS_SVH
`define RGB_HUE_COLOR_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define RHCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhcc assertion failed");
`define RHCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhcc assertion failed");
`else
`define RHCC_ASSERT_IMP(lbl, ante, cons)
`define RHCC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/rhcc_pkg.sv =====
// Types, constants and codes shared by the hue classifier modules.
package rhcc_pkg;

  localparam int CHANNEL_BITS   = 8;
  localparam int NUM_W          = CHANNEL_BITS + 6;
  localparam int PROD_W         = CHANNEL_BITS + 7;
  localparam int Q_W            = 6;
  localparam int DIV_STAGES     = 3;
  localparam int BITS_PER_STAGE = Q_W / DIV_STAGES;

  localparam logic [CHANNEL_BITS-1:0] CHAN_FULL = '1;

  localparam logic [1:0] CFG_HUE_TOL = 2'd0;
  localparam logic [1:0] CFG_SAT_MIN = 2'd1;
  localparam logic [1:0] CFG_VAL_MIN = 2'd2;

  localparam logic [5:0] HUE_TOL_RESET = 6'd20;
  localparam logic [6:0] SAT_MIN_RESET = 7'd80;
  localparam logic [6:0] VAL_MIN_RESET = 7'd40;

  localparam logic [2:0] CLS_NONE    = 3'd0;
  localparam logic [2:0] CLS_BLUE    = 3'd1;
  localparam logic [2:0] CLS_GREEN   = 3'd2;
  localparam logic [2:0] CLS_CYAN    = 3'd3;
  localparam logic [2:0] CLS_RED     = 3'd4;
  localparam logic [2:0] CLS_MAGENTA = 3'd5;
  localparam logic [2:0] CLS_YELLOW  = 3'd6;

  localparam logic [23:0] CODE_NONE    = 24'h000000;
  localparam logic [23:0] CODE_BLUE    = 24'h0000FF;
  localparam logic [23:0] CODE_GREEN   = 24'h00FF00;
  localparam logic [23:0] CODE_CYAN    = 24'h00FFFF;
  localparam logic [23:0] CODE_RED     = 24'hFF0000;
  localparam logic [23:0] CODE_MAGENTA = 24'hFF00FF;
  localparam logic [23:0] CODE_YELLOW  = 24'hFFFF00;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [8:0]  hue_deg;
    logic        class_found;
    logic [2:0]  class_index;
    logic [23:0] color_code;
  } pix_out_t;

  typedef struct packed {
    logic [5:0] hue_win;
    logic [6:0] saturation_min_pct;
    logic [6:0] value_min_pct;
  } cfg_t;

  typedef struct packed {
    sector_t sector;
    logic    neg;
    logic    flat;
    logic    pass;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0]        num;
    logic [CHANNEL_BITS-1:0] delta;
    side_t                   side;
  } div_in_t;

  typedef struct packed {
    logic [NUM_W-1:0]        rem;
    logic [CHANNEL_BITS-1:0] delta;
    logic [Q_W-1:0]          quot;
    side_t                   side;
  } div_st_t;

  typedef struct packed {
    logic [Q_W-1:0] quot;
    logic           rem_nz;
    side_t          side;
  } div_out_t;

endpackage

// ===== rtl/rhcc_front.sv =====
// Front stages: channel extrema, sector, scaled difference and threshold checks.
module rhcc_front import rhcc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    valid_i,
  input  pix_in_t pix_i,
  output logic    ready_o,
  output logic    valid_o,
  output div_in_t data_o,
  input  logic    ready_i
);

  logic                    s1_v_r;
  logic [CHANNEL_BITS-1:0] s1_mx_r;
  logic [CHANNEL_BITS-1:0] s1_delta_r;
  logic [CHANNEL_BITS-1:0] s1_adiff_r;
  sector_t                 s1_sector_r;
  logic                    s1_neg_r;

  logic                    s2_v_r;
  div_in_t                 s2_r;

  logic                    s1_ld;
  logic                    s2_ld;

  logic [CHANNEL_BITS-1:0] s1_mx_nxt;
  logic [CHANNEL_BITS-1:0] s1_delta_nxt;
  logic [CHANNEL_BITS-1:0] s1_adiff_nxt;
  sector_t                 s1_sector_nxt;
  logic                    s1_neg_nxt;
  div_in_t                 s2_nxt;

  assign s2_ld   = !s2_v_r || ready_i;
  assign s1_ld   = !s1_v_r || s2_ld;
  assign ready_o = s1_ld;
  assign valid_o = s2_v_r;
  assign data_o  = s2_r;

  always_comb begin
    logic [CHANNEL_BITS-1:0] r;
    logic [CHANNEL_BITS-1:0] g;
    logic [CHANNEL_BITS-1:0] b;
    logic [CHANNEL_BITS-1:0] mn;
    logic [CHANNEL_BITS-1:0] da;
    logic [CHANNEL_BITS-1:0] db;
    r = pix_i.red_in;
    g = pix_i.green_in;
    b = pix_i.blue_in;
    if (r >= g && r >= b) begin
      s1_sector_nxt = SEC_RED;
      s1_mx_nxt     = r;
      da            = g;
      db            = b;
    end else if (g >= b) begin
      s1_sector_nxt = SEC_GREEN;
      s1_mx_nxt     = g;
      da            = b;
      db            = r;
    end else begin
      s1_sector_nxt = SEC_BLUE;
      s1_mx_nxt     = b;
      da            = r;
      db            = g;
    end
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    s1_delta_nxt = s1_mx_nxt - mn;
    s1_neg_nxt   = da < db;
    s1_adiff_nxt = s1_neg_nxt ? (db - da) : (da - db);
  end

  always_comb begin
    logic [PROD_W-1:0] sat_lhs;
    logic [PROD_W-1:0] sat_rhs;
    logic [PROD_W-1:0] val_lhs;
    logic [PROD_W-1:0] val_rhs;
    sat_lhs = PROD_W'(s1_delta_r) * PROD_W'(100);
    sat_rhs = PROD_W'(cfg.saturation_min_pct) * PROD_W'(s1_mx_r);
    val_lhs = PROD_W'(s1_mx_r) * PROD_W'(100);
    val_rhs = PROD_W'(cfg.value_min_pct) * PROD_W'(CHAN_FULL);
    s2_nxt.num         = (NUM_W'(s1_adiff_r) << 6) - (NUM_W'(s1_adiff_r) << 2);
    s2_nxt.delta       = s1_delta_r;
    s2_nxt.side.sector = s1_sector_r;
    s2_nxt.side.neg    = s1_neg_r;
    s2_nxt.side.flat   = s1_delta_r == '0;
    s2_nxt.side.pass   = (sat_lhs >= sat_rhs) && (val_lhs >= val_rhs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_v_r <= valid_i;
      end
      if (s2_ld) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_mx_r     <= s1_mx_nxt;
      s1_delta_r  <= s1_delta_nxt;
      s1_adiff_r  <= s1_adiff_nxt;
      s1_sector_r <= s1_sector_nxt;
      s1_neg_r    <= s1_neg_nxt;
    end
    if (s2_ld) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

// ===== rtl/rhcc_divider.sv =====
// Pipelined restoring divider producing the sector offset quotient.
module rhcc_divider import rhcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     valid_i,
  input  div_in_t  data_i,
  output logic     ready_o,
  output logic     valid_o,
  output div_out_t data_o,
  input  logic     ready_i
);

  div_st_t                st_in [DIV_STAGES];
  div_st_t                st_nxt [DIV_STAGES];
  div_st_t                st_r [DIV_STAGES];
  logic [DIV_STAGES-1:0]  v_in;
  logic [DIV_STAGES-1:0]  v_r;
  logic [DIV_STAGES:0]    ld;

  assign ld[DIV_STAGES] = ready_i;
  assign ready_o        = ld[0];

  assign st_in[0].rem   = data_i.num;
  assign st_in[0].delta = data_i.delta;
  assign st_in[0].quot  = '0;
  assign st_in[0].side  = data_i.side;
  assign v_in[0]        = valid_i;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign st_in[k] = st_r[k-1];
      assign v_in[k]  = v_r[k-1];
    end

    assign ld[k] = !v_r[k] || ld[k+1];

    always_comb begin
      logic [NUM_W-1:0] trial;
      st_nxt[k] = st_in[k];
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        trial = NUM_W'(st_in[k].delta) << (Q_W - 1 - k * BITS_PER_STAGE - j);
        if (st_nxt[k].rem >= trial) begin
          st_nxt[k].rem = st_nxt[k].rem - trial;
          st_nxt[k].quot[Q_W - 1 - k * BITS_PER_STAGE - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ld[k]) begin
        v_r[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign valid_o       = v_r[DIV_STAGES-1];
  assign data_o.quot   = st_r[DIV_STAGES-1].quot;
  assign data_o.rem_nz = st_r[DIV_STAGES-1].rem != '0;
  assign data_o.side   = st_r[DIV_STAGES-1].side;

endmodule

// ===== rtl/rhcc_classify.sv =====
// Final stage: hue assembly, window matching and the output register.
`include "rgb_hue_color_classifier_macros.svh"
module rhcc_classify import rhcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     valid_i,
  input  div_out_t data_i,
  output logic     ready_o,
  output logic     valid_o,
  output pix_out_t data_o,
  input  logic     stall_i
);

  logic     out_v_r;
  pix_out_t out_r;
  pix_out_t out_nxt;
  logic     ld;

  assign ld      = !out_v_r || !stall_i;
  assign ready_o = ld;
  assign valid_o = out_v_r;
  assign data_o  = out_r;

  function automatic logic in_win(input logic signed [10:0] h,
                                  input logic signed [10:0] c,
                                  input logic signed [10:0] t);
    return (h > c - t) && (h < c + t);
  endfunction

  always_comb begin
    logic [8:0]         q;
    logic [8:0]         hue;
    logic signed [10:0] hs;
    logic signed [10:0] ts;
    q = 9'(data_i.quot);
    case (data_i.side.sector)
      SEC_RED: begin
        hue = data_i.side.neg ? ((q == '0) ? 9'd0 : 9'd360 - q) : q;
      end
      SEC_GREEN: begin
        hue = data_i.side.neg ? 9'd120 - q - 9'(data_i.rem_nz) : 9'd120 + q;
      end
      SEC_BLUE: begin
        hue = data_i.side.neg ? 9'd240 - q - 9'(data_i.rem_nz) : 9'd240 + q;
      end
      default: begin
        hue = 9'd0;
      end
    endcase
    if (data_i.side.flat) begin
      hue = 9'd0;
    end
    hs = signed'({2'b00, hue});
    ts = signed'({5'b00000, cfg.hue_win});
    out_nxt.hue_deg     = hue;
    out_nxt.class_index = CLS_NONE;
    out_nxt.color_code  = CODE_NONE;
    if (data_i.side.pass) begin
      if (in_win(hs, 11'sd240, ts)) begin
        out_nxt.class_index = CLS_BLUE;
        out_nxt.color_code  = CODE_BLUE;
      end else if (in_win(hs, 11'sd120, ts)) begin
        out_nxt.class_index = CLS_GREEN;
        out_nxt.color_code  = CODE_GREEN;
      end else if (in_win(hs, 11'sd180, ts)) begin
        out_nxt.class_index = CLS_CYAN;
        out_nxt.color_code  = CODE_CYAN;
      end else if ((hs > 11'sd360 - ts) || (hs < ts)) begin
        out_nxt.class_index = CLS_RED;
        out_nxt.color_code  = CODE_RED;
      end else if (in_win(hs, 11'sd300, ts)) begin
        out_nxt.class_index = CLS_MAGENTA;
        out_nxt.color_code  = CODE_MAGENTA;
      end else if (in_win(hs, 11'sd60, ts)) begin
        out_nxt.class_index = CLS_YELLOW;
        out_nxt.color_code  = CODE_YELLOW;
      end
    end
    out_nxt.class_found = out_nxt.class_index != CLS_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ld) begin
      out_v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_r <= out_nxt;
    end
  end

  `RHCC_ASSERT_IMP(a_hue_range, out_v_r, out_r.hue_deg < 9'd360)
  `RHCC_ASSERT_IMP(a_miss_clean, out_v_r && !out_r.class_found,
                   out_r.class_index == CLS_NONE && out_r.color_code == CODE_NONE)
  `RHCC_ASSERT_IMP(a_hit_coded, out_v_r && out_r.class_found,
                   out_r.class_index != CLS_NONE && out_r.color_code != CODE_NONE)
  `RHCC_ASSERT_NXT(a_fill_empty, !out_v_r && valid_i, out_v_r)

endmodule

// ===== rtl/rgb_hue_color_classifier.sv =====
// Top level of the RGB hue classifier: configuration registers and stage wiring.
//
// The input channel (in_valid, in_stall, in_data) takes one RGB pixel word per
// cycle while in_stall is low. The result channel (out_valid, out_stall,
// out_data) gives one word per pixel, in order: hue, class flag, index and code.
// A word moves on a rising edge where valid is high and stall is low.
// The configuration port writes cfg_data into the register chosen by cfg_index
// on any edge where cfg_we is high: 0 hue tolerance, 1 saturation percent,
// 2 value percent. Other indexes are ignored.
// A word passes six register stages: two front stages for extrema and
// thresholds, three divider stages of two quotient bits each, and the
// classification stage that holds the output register. Throughput is one
// pixel per cycle while out_stall is low. When the receiver stalls, full
// stages hold their words and empty stages keep filling, so in_stall rises
// only once every stage holds a word.
// Reset clears all stage valid bits and loads the registers with tolerance 20,
// saturation 80 percent and value 40 percent.
module rgb_hue_color_classifier import rhcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pix_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pix_out_t out_data,
  input  logic     cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  cfg_t     cfg_r;
  logic     front_ready;
  logic     front_valid;
  div_in_t  front_data;
  logic     div_ready;
  logic     div_valid;
  div_out_t div_data;
  logic     cls_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hue_win            <= HUE_TOL_RESET;
      cfg_r.saturation_min_pct <= SAT_MIN_RESET;
      cfg_r.value_min_pct      <= VAL_MIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HUE_TOL: begin
          cfg_r.hue_win <= cfg_data[5:0];
        end
        CFG_SAT_MIN: begin
          cfg_r.saturation_min_pct <= cfg_data;
        end
        CFG_VAL_MIN: begin
          cfg_r.value_min_pct <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !front_ready;

  rhcc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .valid_i (in_valid),
    .pix_i   (in_data),
    .ready_o (front_ready),
    .valid_o (front_valid),
    .data_o  (front_data),
    .ready_i (div_ready)
  );

  rhcc_divider u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (front_valid),
    .data_i  (front_data),
    .ready_o (div_ready),
    .valid_o (div_valid),
    .data_o  (div_data),
    .ready_i (cls_ready)
  );

  rhcc_classify u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .valid_i (div_valid),
    .data_i  (div_data),
    .ready_o (cls_ready),
    .valid_o (out_valid),
    .data_o  (out_data),
    .stall_i (out_stall)
  );

endmodule

// ===== verif/tb_rgb_hue_color_classifier.sv =====
// Self-checking testbench for the RGB hue classifier with directed and random pixels.
`timescale 1ns / 1ps

module tb_rgb_hue_color_classifier;
  import rhcc_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 40;
  localparam int DRAIN_LIMIT = 2000;

  typedef struct {
    pix_in_t  pix;
    bit       known;
    pix_out_t want;
  } dir_row_t;

  typedef struct {
    int tol;
    int sat;
    int val;
    int count;
    bit quiet;
    bit hold;
    bit pause;
  } phase_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  pix_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pix_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_HUE_TOL;
  logic [6:0] cfg_data = '0;

  logic [5:0] tol_q = HUE_TOL_RESET;
  logic [6:0] sat_q = SAT_MIN_RESET;
  logic [6:0] val_q = VAL_MIN_RESET;

  pix_out_t pending_results[$];
  int  error_count = 0;
  int  pixels_sent = 0;
  int  results_seen = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  dir_row_t directed_rows[15] = '{
    '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{9'd0,   1'b0, CLS_NONE,    CODE_NONE   }},
    '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{9'd0,   1'b1, CLS_RED,     CODE_RED    }},
    '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{9'd120, 1'b1, CLS_GREEN,   CODE_GREEN  }},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{9'd240, 1'b1, CLS_BLUE,    CODE_BLUE   }},
    '{'{8'd255, 8'd255, 8'd0  }, 1'b1, '{9'd60,  1'b1, CLS_YELLOW,  CODE_YELLOW }},
    '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{9'd180, 1'b1, CLS_CYAN,    CODE_CYAN   }},
    '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{9'd300, 1'b1, CLS_MAGENTA, CODE_MAGENTA}},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{9'd0,   1'b0, CLS_NONE,    CODE_NONE   }},
    '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{9'd0,   1'b0, CLS_NONE,    CODE_NONE   }},
    '{'{8'd255, 8'd0,   8'd10 }, 1'b0, '0},
    '{'{8'd50,  8'd0,   8'd0  }, 1'b0, '0},
    '{'{8'd255, 8'd200, 8'd200}, 1'b0, '0},
    '{'{8'd255, 8'd0,   8'd85 }, 1'b0, '0},
    '{'{8'd0,   8'd255, 8'd85 }, 1'b0, '0},
    '{'{8'd170, 8'd255, 8'd0  }, 1'b0, '0}
  };

  phase_t phases[9] = '{
    '{20,  80,  40, 150, 1'b0, 1'b0, 1'b0},
    '{60,   0,   0, 250, 1'b0, 1'b1, 1'b0},
    '{0,   50,  20, 150, 1'b0, 1'b0, 1'b0},
    '{127,  0,   0, 200, 1'b0, 1'b0, 1'b0},
    '{1,  100, 100, 200, 1'b0, 1'b0, 1'b0},
    '{30, 127,  10, 100, 1'b0, 1'b0, 1'b0},
    '{45,  30, 127, 100, 1'b0, 1'b0, 1'b0},
    '{40,  20,  10, 300, 1'b1, 1'b0, 1'b0},
    '{15,  60,  30, 200, 1'b0, 1'b0, 1'b1}
  };

  rgb_hue_color_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic pix_out_t classify_pixel(pix_in_t p);
    int r, g, b, mx, mn, dl, h, t;
    bit pass;
    pix_out_t o;
    r = p.red_in;
    g = p.green_in;
    b = p.blue_in;
    mx = (r >= g) ? r : g;
    mx = (mx >= b) ? mx : b;
    mn = (r <= g) ? r : g;
    mn = (mn <= b) ? mn : b;
    dl = mx - mn;
    if (dl == 0) begin
      h = 0;
    end else if (mx == r) begin
      h = (60 * (g - b)) / dl;
      if (h < 0) begin
        h = h + 360;
      end
    end else if (mx == g) begin
      h = (120 * dl + 60 * (b - r)) / dl;
    end else begin
      h = (240 * dl + 60 * (r - g)) / dl;
    end
    t = int'(tol_q);
    pass = !(dl * 100 < int'(sat_q) * mx) && !(mx * 100 < int'(val_q) * int'(CHAN_FULL));
    o.hue_deg = h[8:0];
    o.class_index = CLS_NONE;
    o.color_code = CODE_NONE;
    if (pass) begin
      if (h > 240 - t && h < 240 + t) begin
        o.class_index = CLS_BLUE;
        o.color_code = CODE_BLUE;
      end else if (h > 120 - t && h < 120 + t) begin
        o.class_index = CLS_GREEN;
        o.color_code = CODE_GREEN;
      end else if (h > 180 - t && h < 180 + t) begin
        o.class_index = CLS_CYAN;
        o.color_code = CODE_CYAN;
      end else if ((h > 360 - t && h <= 360) || (h >= 0 && h < t)) begin
        o.class_index = CLS_RED;
        o.color_code = CODE_RED;
      end else if (h > 300 - t && h < 300 + t) begin
        o.class_index = CLS_MAGENTA;
        o.color_code = CODE_MAGENTA;
      end else if (h > 60 - t && h < 60 + t) begin
        o.class_index = CLS_YELLOW;
        o.color_code = CODE_YELLOW;
      end
    end
    o.class_found = (o.class_index != CLS_NONE);
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s of word %0d: got %0d, expected %0d", what, results_seen, got, want);
    error_count++;
  endtask

  task automatic write_register(logic [1:0] idx, logic [6:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_HUE_TOL: tol_q = data[5:0];
      CFG_SAT_MIN: sat_q = data;
      CFG_VAL_MIN: val_q = data;
      default: ;
    endcase
  endtask

  task automatic drive_pixel(pix_in_t p, bit known, pix_out_t want);
    pix_out_t exp_word;
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 7) begin
      in_valid = 1'b0;
      in_data = pix_in_t'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = p;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    exp_word = known ? want : classify_pixel(p);
    pending_results = {pending_results, exp_word};
    pixels_sent++;
  endtask

  task automatic wait_for_results();
    int n;
    n = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_results.size() != 0) begin
      $display("%0d expected words never arrived", pending_results.size());
      error_count++;
      pending_results.delete();
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall = 1'b1;
    end else begin
      out_stall = idle_on && ($urandom_range(99) < 7);
    end
  end

  always @(posedge clk) begin
    pix_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result word: %h", out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.hue_deg !== want.hue_deg) begin
          report_mismatch("hue_deg", out_data.hue_deg, want.hue_deg);
        end
        if (out_data.class_found !== want.class_found) begin
          report_mismatch("class_found", out_data.class_found, want.class_found);
        end
        if (out_data.class_index !== want.class_index) begin
          report_mismatch("class_index", out_data.class_index, want.class_index);
        end
        if (out_data.color_code !== want.color_code) begin
          report_mismatch("color_code", out_data.color_code, want.color_code);
        end
      end
      results_seen++;
    end
  end

  initial begin
    pix_in_t p;
    int ch[3];
    int mode, i, j, tmp;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[k]) begin
      drive_pixel(directed_rows[k].pix, directed_rows[k].known, directed_rows[k].want);
    end

    foreach (phases[ph]) begin
      if (ph != 0) begin
        wait_for_results();
        write_register(CFG_HUE_TOL, phases[ph].tol[6:0]);
        write_register(CFG_SAT_MIN, phases[ph].sat[6:0]);
        write_register(CFG_VAL_MIN, phases[ph].val[6:0]);
        if (ph == 2) begin
          write_register(CFG_UNUSED, 7'd5);
        end
      end
      idle_on = !phases[ph].quiet;
      for (int n = 0; n < phases[ph].count; n++) begin
        if (phases[ph].hold && n == 10) begin
          hold_req = 1'b1;
        end
        if (phases[ph].pause && n == phases[ph].count / 2) begin
          wait_for_results();
        end
        mode = $urandom_range(9);
        if (mode < 4) begin
          p = pix_in_t'($urandom);
        end else if (mode == 4) begin
          tmp = $urandom_range(255);
          p = '{tmp[7:0], tmp[7:0], tmp[7:0]};
        end else begin
          ch[0] = $urandom_range(255, 150);
          ch[1] = $urandom_range(40, 0);
          ch[2] = (mode == 9) ? ch[0] : $urandom_range(ch[0], ch[1]);
          i = $urandom_range(2);
          tmp = ch[0];
          ch[0] = ch[i];
          ch[i] = tmp;
          j = $urandom_range(2, 1);
          tmp = ch[1];
          ch[1] = ch[j];
          ch[j] = tmp;
          p = '{ch[0][7:0], ch[1][7:0], ch[2][7:0]};
        end
        drive_pixel(p, 1'b0, '0);
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d pixels over %0d register settings and checked %0d result words,",
             pixels_sent, $size(phases), results_seen);
    $display("with a long receiver hold, a drained pause and a stretch without idle cycles.");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rhcc_pkg.sv
rtl/rhcc_front.sv
rtl/rhcc_divider.sv
rtl/rhcc_classify.sv
rtl/rgb_hue_color_classifier.sv
verif/tb_rgb_hue_color_classifier.sv
